// File: rtl/core/frgs_pkg.sv
// ----------------------------------------------------------------------------
// frgs_pkg
// Shared types and constants for the free range gap subtractor.
// ----------------------------------------------------------------------------
package frgs_pkg;

   localparam int MAX_RANGES_DEF = 64;

   typedef enum logic [1:0] {
      CMD_RESTORE  = 2'd0,
      CMD_SUBTRACT = 2'd1,
      CMD_READ     = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_WINDOW_LOW  = 1'b0,
      CSR_WINDOW_HIGH = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UP,
      ST_SPLIT2,
      ST_COPY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] low;
      logic [31:0] high;
   } entry_type;

endpackage

// File: rtl/core/frgs_if.sv
// ----------------------------------------------------------------------------
// frgs_req_if / frgs_rsp_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface frgs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] gap_start;
   logic [31:0] gap_end;
   logic [5:0]  entry_index;

   modport source (output valid, command, gap_start, gap_end, entry_index, input ready);
   modport sink   (input valid, command, gap_start, gap_end, entry_index, output ready);
endinterface

interface frgs_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  range_count;
   logic [31:0] entry_low;
   logic [31:0] entry_high;
   logic        entry_valid;
   logic        table_full;

   modport source (output valid, range_count, entry_low, entry_high, entry_valid,
                   table_full, input ready);
   modport sink   (input valid, range_count, entry_low, entry_high, entry_valid,
                   table_full, output ready);
endinterface

// File: rtl/core/frgs_table.sv
// ----------------------------------------------------------------------------
// frgs_table
// Range table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frgs_table
   import frgs_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF,
   localparam int AW = $clog2(MAX_RANGES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [MAX_RANGES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/free_range_gap_subtractor.sv
// ----------------------------------------------------------------------------
// free_range_gap_subtractor
// Keeps a table of free inclusive address ranges and subtracts gaps from it.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          word
//  req      in         valid/ready        command, gap_start, gap_end, entry_index
//  rsp      out        valid/ready        range_count, entry_low/high, flags
//  csr      in         csr_we, no stall   csr_index, csr_wdata
//
// A restore, an unused command or a read beyond the count goes from acceptance
// straight to the result state, a read of a held entry through a read state. A
// subtract scans the table entry by entry, moves the tail up when a split finds no
// free slot, writes the upper half of a split and copies the remaining entries; the
// single read port of the table sets this pace.
// Reset is synchronous and leaves the table holding the whole window.
// A word is accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module free_range_gap_subtractor
   import frgs_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   frgs_req_if.sink          req,
   frgs_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);

   state_type   state_ff, state_in;
   logic [31:0] win_low_ff, win_low_in, win_high_ff, win_high_in;
   logic [CW-1:0] cnt_ff, cnt_in, rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] end_ff, end_in;
   logic [31:0] gs_ff, gs_in, ge_ff, ge_in;
   entry_type   piece_ff, piece_in;
   logic        up_ff, up_in, full_ff, full_in;
   entry_type   res_ff, res_in;
   logic        res_valid_ff, res_valid_in;
   logic        init_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;
   entry_type   rsp_entry_ff, rsp_entry_in;
   logic        rsp_evalid_ff, rsp_evalid_in, rsp_full_ff, rsp_full_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata, mem_rdata;

   logic        accept;
   logic [31:0] s_clamp, e_clamp, lo, hi, new_lo, new_hi;
   logic        c_cover, c_low, c_high, c_split, c_drop, c_full, c_last;
   logic [CW-1:0] r_next;

   frgs_table #(.MAX_RANGES(MAX_RANGES)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req.ready = (state_ff == ST_IDLE) && !init_ff;
   assign accept    = req.valid && req.ready;
   assign s_clamp   = (req.gap_start < win_low_ff) ? win_low_ff : req.gap_start;
   assign e_clamp   = (req.gap_end > win_high_ff) ? win_high_ff : req.gap_end;

   // Classification of the entry just read during the scan.
   assign lo      = mem_rdata.low;
   assign hi      = mem_rdata.high;
   assign new_lo  = ge_ff + 32'd1;
   assign new_hi  = gs_ff - 32'd1;
   assign c_cover = (gs_ff <= lo) && (ge_ff >= hi);
   assign c_low   = !c_cover && (gs_ff <= lo) && (ge_ff >= lo);
   assign c_high  = !c_cover && !c_low && (gs_ff <= hi) && (ge_ff >= hi);
   assign c_split = !c_cover && !c_low && !c_high && (gs_ff > lo) && (ge_ff < hi);
   assign c_drop  = c_cover || (c_low && (new_lo > hi)) || (c_high && (lo > new_hi));
   assign c_full  = c_split && (cnt_ff >= CW'(MAX_RANGES));
   assign r_next  = CW'(rd_ptr_ff + 1'b1);
   assign c_last  = (r_next == end_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req.command == CMD_READ) begin
                  state_in = (32'(req.entry_index) < 32'(cnt_ff)) ? ST_READ : ST_DONE;
               end else if (req.command == CMD_SUBTRACT && s_clamp <= e_clamp
                            && cnt_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_SCAN: begin
            priority if (c_full) begin
               state_in = ST_DONE;
            end else if (c_split) begin
               state_in = (wr_ptr_ff == rd_ptr_ff && !c_last) ? ST_UP : ST_SPLIT2;
            end else if (c_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_UP: begin
            if (rd_ptr_ff == CW'(wr_ptr_ff + 1'b1)) begin
               state_in = ST_SPLIT2;
            end
         end
         ST_SPLIT2: state_in = (!up_ff && !c_last) ? ST_COPY : ST_DONE;
         ST_COPY:   state_in = c_last ? ST_DONE : ST_COPY;
         ST_DONE:   state_in = (!rsp_valid_ff || rsp.ready) ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and table accesses.
   always_comb begin
      win_low_in    = win_low_ff;
      win_high_in   = win_high_ff;
      cnt_in        = cnt_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      end_in        = end_ff;
      gs_in         = gs_ff;
      ge_in         = ge_ff;
      piece_in      = piece_ff;
      up_in         = up_ff;
      full_in       = full_ff;
      res_in        = res_ff;
      res_valid_in  = res_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_evalid_in = rsp_evalid_ff;
      rsp_full_in   = rsp_full_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(wr_ptr_ff);
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = AW'(r_next);

      if (csr_we) begin
         if (csr_index == CSR_WINDOW_LOW) begin
            win_low_in = csr_wdata;
         end else begin
            win_high_in = csr_wdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (init_ff) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = '{low: win_low_ff, high: win_high_ff};
            end else if (accept) begin
               res_in       = '0;
               res_valid_in = 1'b0;
               full_in      = 1'b0;
               gs_in        = s_clamp;
               ge_in        = e_clamp;
               rd_ptr_in    = '0;
               wr_ptr_in    = '0;
               end_in       = cnt_ff;
               unique case (req.command)
                  CMD_RESTORE: begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = '{low: win_low_ff, high: win_high_ff};
                     cnt_in    = CW'(1);
                  end
                  CMD_SUBTRACT: begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                  end
                  CMD_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req.entry_index);
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            res_in       = mem_rdata;
            res_valid_in = 1'b1;
         end
         ST_SCAN: begin
            rd_ptr_in = r_next;
            priority if (c_full) begin
               full_in = 1'b1;
            end else if (c_split) begin
               mem_we    = 1'b1;
               mem_wdata = '{low: lo, high: new_hi};
               piece_in  = '{low: new_lo, high: hi};
               cnt_in    = CW'(cnt_ff + 1'b1);
               rd_ptr_in = rd_ptr_ff;
               up_in     = (wr_ptr_ff == rd_ptr_ff);
               if (wr_ptr_ff == rd_ptr_ff && !c_last) begin
                  // Open a slot: move the tail up by one, last entry first.
                  mem_re    = 1'b1;
                  mem_raddr = AW'(end_ff - 1'b1);
                  rd_ptr_in = CW'(end_ff - 1'b1);
               end
            end else if (c_drop) begin
               cnt_in = CW'(cnt_ff - 1'b1);
               mem_re = !c_last;
            end else begin
               mem_we = 1'b1;
               if (c_low) begin
                  mem_wdata = '{low: new_lo, high: hi};
               end else if (c_high) begin
                  mem_wdata = '{low: lo, high: new_hi};
               end
               wr_ptr_in = CW'(wr_ptr_ff + 1'b1);
               mem_re    = !c_last;
            end
         end
         ST_UP: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_ptr_ff + 1'b1);
            if (rd_ptr_ff != CW'(wr_ptr_ff + 1'b1)) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(rd_ptr_ff - 1'b1);
               rd_ptr_in = CW'(rd_ptr_ff - 1'b1);
            end else begin
               rd_ptr_in = wr_ptr_ff;
            end
         end
         ST_SPLIT2: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(wr_ptr_ff + 1'b1);
            mem_wdata = piece_ff;
            if (!up_ff && !c_last) begin
               mem_re    = 1'b1;
               rd_ptr_in = r_next;
               wr_ptr_in = CW'(wr_ptr_ff + 2'd2);
            end
         end
         ST_COPY: begin
            mem_we    = 1'b1;
            wr_ptr_in = CW'(wr_ptr_ff + 1'b1);
            rd_ptr_in = r_next;
            mem_re    = !c_last;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = 7'(cnt_ff);
               rsp_entry_in  = res_ff;
               rsp_evalid_in = res_valid_ff;
               rsp_full_in   = full_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= 1'b1;
         win_low_ff   <= '0;
         win_high_ff  <= '1;
         cnt_ff       <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= 1'b0;
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      end_ff        <= end_in;
      gs_ff         <= gs_in;
      ge_ff         <= ge_in;
      piece_ff      <= piece_in;
      up_ff         <= up_in;
      full_ff       <= full_in;
      res_ff        <= res_in;
      res_valid_ff  <= res_valid_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_evalid_ff <= rsp_evalid_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.range_count = rsp_count_ff;
   assign rsp.entry_low   = rsp_entry_ff.low;
   assign rsp.entry_high  = rsp_entry_ff.high;
   assign rsp.entry_valid = rsp_evalid_ff;
   assign rsp.table_full  = rsp_full_ff;

endmodule

// File: bench/free_range_gap_subtractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_range_gap_subtractor_tb
// Drives restore, subtract, read and unused words into the free range table, keeps a
// shadow copy of the table, and compares every result word field by field.
// ----------------------------------------------------------------------------
module free_range_gap_subtractor_tb;
   import frgs_pkg::*;

   localparam int DEPTH = 64;

   typedef struct {
      logic [6:0]  range_count;
      logic [31:0] entry_low;
      logic [31:0] entry_high;
      logic        entry_valid;
      logic        table_full;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   frgs_req_if req ();
   frgs_rsp_if rsp ();

   free_range_gap_subtractor dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the block's window and range table.
   logic [31:0] win_low, win_high;
   logic [31:0] shadow_low [DEPTH];
   logic [31:0] shadow_high [DEPTH];
   int          shadow_count;
   result_type  pending_results [$];
   int          failures = 0;
   int          hold_cycles = 0;

   function automatic void remove_range(int pos);
      for (int k = pos; k < shadow_count - 1; k++) begin
         shadow_low[k]  = shadow_low[k + 1];
         shadow_high[k] = shadow_high[k + 1];
      end
      shadow_count--;
   endfunction

   function automatic logic carve_gap(logic [31:0] s, logic [31:0] e);
      int          i;
      logic [31:0] lo, hi;
      i = 0;
      if (s < win_low) s = win_low;
      if (e > win_high) e = win_high;
      if (s > e) return 1'b0;
      while (i < shadow_count) begin
         lo = shadow_low[i];
         hi = shadow_high[i];
         if (s <= lo && e >= hi) begin
            remove_range(i);
         end else if (s <= lo && e >= lo) begin
            shadow_low[i] = e + 1;
            if (shadow_low[i] > hi) remove_range(i); else i++;
         end else if (s <= hi && e >= hi) begin
            shadow_high[i] = s - 1;
            if (lo > shadow_high[i]) remove_range(i); else i++;
         end else if (s > lo && e < hi) begin
            if (shadow_count >= DEPTH) return 1'b1;
            for (int k = shadow_count; k > i + 1; k--) begin
               shadow_low[k]  = shadow_low[k - 1];
               shadow_high[k] = shadow_high[k - 1];
            end
            shadow_high[i]     = s - 1;
            shadow_low[i + 1]  = e + 1;
            shadow_high[i + 1] = hi;
            shadow_count++;
            return 1'b0;
         end else begin
            i++;
         end
      end
      return 1'b0;
   endfunction

   function automatic result_type predict_result(cmd_type cmd, logic [31:0] gs,
                                                 logic [31:0] ge, logic [5:0] idx);
      result_type r;
      r = '{default: '0};
      case (cmd)
         CMD_RESTORE: begin
            shadow_low[0]  = win_low;
            shadow_high[0] = win_high;
            shadow_count   = 1;
         end
         CMD_SUBTRACT: r.table_full = carve_gap(gs, ge);
         CMD_READ: begin
            if (idx < shadow_count) begin
               r.entry_low   = shadow_low[idx];
               r.entry_high  = shadow_high[idx];
               r.entry_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.range_count = shadow_count[6:0];
      return r;
   endfunction

   // Valid stays high on return so that a word with no gap follows directly;
   // drain() drops it when sending stops.
   task automatic send_word(cmd_type cmd, logic [31:0] gs, logic [31:0] ge,
                            logic [5:0] idx, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.command     <= cmd;
      req.gap_start   <= gs;
      req.gap_end     <= ge;
      req.entry_index <= idx;
      do @(posedge clock); while (!req.ready);
      pending_results = {pending_results, predict_result(cmd, gs, ge, idx)};
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus a long hold when hold_cycles is set.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.range_count !== want.range_count) begin
               $error("range_count exp %0d got %0d", want.range_count, rsp.range_count);
               failures++;
            end
            if (rsp.entry_low !== want.entry_low) begin
               $error("entry_low exp %h got %h", want.entry_low, rsp.entry_low);
               failures++;
            end
            if (rsp.entry_high !== want.entry_high) begin
               $error("entry_high exp %h got %h", want.entry_high, rsp.entry_high);
               failures++;
            end
            if (rsp.entry_valid !== want.entry_valid) begin
               $error("entry_valid exp %b got %b", want.entry_valid, rsp.entry_valid);
               failures++;
            end
            if (rsp.table_full !== want.table_full) begin
               $error("table_full exp %b got %b", want.table_full, rsp.table_full);
               failures++;
            end
         end
      end
   end

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_window(logic [31:0] lo, logic [31:0] hi);
      drain();
      csr_we <= 1'b1; csr_index <= CSR_WINDOW_LOW; csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_WINDOW_HIGH; csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      win_low  = lo;
      win_high = hi;
   endtask

   function automatic logic [31:0] rand_addr();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_READ, 0, 0, 6'd63);
      send_word(CMD_SUBTRACT, 32'h10, 32'h1F, 0);
      send_word(CMD_SUBTRACT, 32'h30, 32'h20, 0);          // inverted gap
      send_word(CMD_SUBTRACT, 32'h0, 32'h5, 0);            // trim low end
      send_word(CMD_SUBTRACT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
      send_word(CMD_SUBTRACT, 32'h6, 32'hF, 0);            // delete whole range
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_READ, 0, 0, 1);
      send_word(CMD_READ, 0, 0, 2);
      send_word(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
      send_word(CMD_SUBTRACT, 32'h0, 32'hFFFF_FFFF, 0);    // empties the table
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_RESTORE, 0, 0, 0);
   endtask

   // Splits the window with 1-address gaps until the table refuses.
   task automatic test_table_full(logic [31:0] base);
      send_word(CMD_RESTORE, 0, 0, 0);
      for (int k = 0; k < DEPTH + 2; k++)
         send_word(CMD_SUBTRACT, base + 2 * k + 1, base + 2 * k + 1, 0, k[0]);
      for (int k = 0; k < 4; k++)
         send_word(CMD_READ, 0, 0, 6'($urandom_range(60, 63)));
   endtask

   task automatic test_window_change();
      write_window(32'h1000, 32'h1FFF);
      send_word(CMD_SUBTRACT, 32'h0, 32'h1800, 0);         // window stays until restore
      send_word(CMD_RESTORE, 0, 0, 0);
      send_word(CMD_SUBTRACT, 32'h0, 32'h1003, 0);
      send_word(CMD_SUBTRACT, 32'h1F00, 32'hFFFF_FFFF, 0);
      send_word(CMD_READ, 0, 0, 0);
      write_window(32'h500, 32'h400);                      // inverted window
      send_word(CMD_RESTORE, 0, 0, 0);
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_SUBTRACT, 32'h400, 32'h500, 0);
      write_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_RESTORE, 0, 0, 0);
      send_word(CMD_SUBTRACT, 32'h0, 32'hFFFF_FFFF, 0);
   endtask

   // Long receiver hold while words keep coming, so the block must stall.
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int k = 0; k < 12; k++)
         send_word(CMD_READ, 0, 0, 6'(k), 1);
   endtask

   task automatic test_random(int count, logic [31:0] span);
      logic [31:0] s, l;
      cmd_type     cmd;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0: cmd = CMD_RESTORE;
            1: cmd = CMD_NONE;
            2, 3, 4, 5, 6, 7: cmd = CMD_READ;
            default: cmd = CMD_SUBTRACT;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            s = rand_addr(); l = rand_addr();
         end else begin
            s = win_low + $urandom_range(0, span);
            l = s + $urandom_range(0, span >> 4);
         end
         send_word(cmd, s, l, 6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.command = CMD_NONE;
      req.gap_start = '0;
      req.gap_end = '0;
      req.entry_index = '0;
      win_low = 32'h0;
      win_high = 32'hFFFF_FFFF;
      shadow_low[0] = win_low;
      shadow_high[0] = win_high;
      shadow_count = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_full(32'h100);
      test_backpressure();
      test_window_change();
      write_window(32'h0, 32'hFFFF_FFFF);
      test_random(400, 32'h7FFF_FFFF);
      write_window(32'h1_0000, 32'h1_0FFF);
      test_table_full(32'h1_0000);
      test_random(400, 32'h1000);
      write_window(32'h0, 32'hFF);
      test_random(300, 32'hFF);
      drain();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule
